>>> rtl/tlss_pkg.sv
// ----------------------------------------------------------------------------
// tlss_pkg
// Shared types and constants for the triangle list to strip stitcher.
// ----------------------------------------------------------------------------
package tlss_pkg;

    localparam int INDEX_BITS_DEFAULT = 16;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_VERTEX = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    // Position within the longest run: end, begin, then the three vertices
    typedef enum logic [2:0] {
        SLOT_END   = 3'd0,
        SLOT_BEGIN = 3'd1,
        SLOT_A     = 3'd2,
        SLOT_B     = 3'd3,
        SLOT_C     = 3'd4
    } slot_t;

endpackage

>>> rtl/triangle_list_strip_stitcher.sv
// ----------------------------------------------------------------------------
// triangle_list_strip_stitcher
// Re-emits an indexed triangle list as triangle strips, one triangle per
// input item, one strip command or vertex per result item.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_stall  | action, index_a, index_b, index_c
//  output   | out_valid / out_stall| kind, vertex_index, last_of_run
//
// A triangle that continues the open strip, and an end of list that closes
// one, yield one result and stream at one item per cycle while out_stall is
// low. A triangle that starts a strip yields four results, one that breaks a
// strip five; the run sequencer emits one result per cycle while out_stall is
// low, so such an item holds the output until its last result is taken. The
// next item is taken in the same cycle that the last result of a run is taken.
// An end of list with no strip open yields nothing.
// Reset clears the previous triangle, parity, strip-open flag and the run
// sequencer. A stall on the output holds the current result and, once the
// run is not finishing, stalls the input.
// ----------------------------------------------------------------------------
module triangle_list_strip_stitcher
    import tlss_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [INDEX_BITS-1:0] index_a,
    input  logic [INDEX_BITS-1:0] index_b,
    input  logic [INDEX_BITS-1:0] index_c,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            kind,
    output logic [INDEX_BITS-1:0] vertex_index,
    output logic                  last_of_run
);

    // Previous triangle; also the vertex source for the run being emitted,
    // since a new triangle is only taken as the current run finishes.
    logic [INDEX_BITS-1:0] prev_first_reg,  prev_first_next;
    logic [INDEX_BITS-1:0] prev_second_reg, prev_second_next;
    logic [INDEX_BITS-1:0] prev_third_reg,  prev_third_next;
    logic                  even_parity_reg, even_parity_next;
    logic                  strip_open_reg,  strip_open_next;

    // Run sequencer: current slot and the slot that ends the run
    logic                  busy_reg, busy_next;
    slot_t                 slot_reg, slot_next;
    slot_t                 last_slot_reg, last_slot_next;

    logic                  accept;
    logic                  take;
    logic                  done;
    logic                  cont;
    kind_t                 kind_out;

    assign take      = busy_reg && !out_stall;
    assign done      = take && (slot_reg == last_slot_reg);
    assign in_stall  = busy_reg && !done;
    assign accept    = in_valid && !in_stall;
    assign out_valid = busy_reg;

    // Continuation test under the alternating parity rule
    always_comb
    begin
        if (!strip_open_reg)
        begin
            cont = 1'b0;
        end
        else if (!even_parity_reg)
        begin
            cont = (index_a == prev_third_reg) && (index_b == prev_second_reg);
        end
        else
        begin
            cont = (index_a == prev_first_reg) && (index_b == prev_third_reg);
        end
    end

    // Strip state update on accept
    always_comb
    begin
        prev_first_next  = prev_first_reg;
        prev_second_next = prev_second_reg;
        prev_third_next  = prev_third_reg;
        even_parity_next = even_parity_reg;
        strip_open_next  = strip_open_reg;
        if (accept)
        begin
            if (action)
            begin
                // End of list: close the strip and reset parity
                strip_open_next  = 1'b0;
                even_parity_next = 1'b0;
            end
            else
            begin
                prev_first_next  = index_a;
                prev_second_next = index_b;
                prev_third_next  = index_c;
                if (cont)
                begin
                    even_parity_next = !even_parity_reg;
                end
                else
                begin
                    strip_open_next  = 1'b1;
                    even_parity_next = 1'b0;
                end
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        busy_next      = busy_reg;
        slot_next      = slot_reg;
        last_slot_next = last_slot_reg;
        if (take && !done)
        begin
            case (slot_reg)
                SLOT_END:   slot_next = SLOT_BEGIN;
                SLOT_BEGIN: slot_next = SLOT_A;
                SLOT_A:     slot_next = SLOT_B;
                SLOT_B:     slot_next = SLOT_C;
                default:    slot_next = SLOT_C;
            endcase
        end
        if (done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            if (action)
            begin
                // Drop an end of list with nothing open
                busy_next      = strip_open_reg;
                slot_next      = SLOT_END;
                last_slot_next = SLOT_END;
            end
            else
            begin
                busy_next      = 1'b1;
                last_slot_next = SLOT_C;
                if (cont)
                begin
                    slot_next = SLOT_C;
                end
                else if (strip_open_reg)
                begin
                    slot_next = SLOT_END;
                end
                else
                begin
                    slot_next = SLOT_BEGIN;
                end
            end
        end
    end

    // Sequencer outputs
    always_comb
    begin
        case (slot_reg)
            SLOT_END:
            begin
                kind_out     = KIND_END;
                vertex_index = '0;
            end
            SLOT_BEGIN:
            begin
                kind_out     = KIND_BEGIN;
                vertex_index = '0;
            end
            SLOT_A:
            begin
                kind_out     = KIND_VERTEX;
                vertex_index = prev_first_reg;
            end
            SLOT_B:
            begin
                kind_out     = KIND_VERTEX;
                vertex_index = prev_second_reg;
            end
            SLOT_C:
            begin
                kind_out     = KIND_VERTEX;
                vertex_index = prev_third_reg;
            end
            default:
            begin
                kind_out     = KIND_END;
                vertex_index = '0;
            end
        endcase
    end

    assign kind        = kind_out;
    assign last_of_run = (slot_reg == last_slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_first_reg  <= '0;
            prev_second_reg <= '0;
            prev_third_reg  <= '0;
            even_parity_reg <= 1'b0;
            strip_open_reg  <= 1'b0;
            busy_reg        <= 1'b0;
            slot_reg        <= SLOT_END;
            last_slot_reg   <= SLOT_END;
        end
        else
        begin
            prev_first_reg  <= prev_first_next;
            prev_second_reg <= prev_second_next;
            prev_third_reg  <= prev_third_next;
            even_parity_reg <= even_parity_next;
            strip_open_reg  <= strip_open_next;
            busy_reg        <= busy_next;
            slot_reg        <= slot_next;
            last_slot_reg   <= last_slot_next;
        end
    end

    // Even parity only exists inside an open strip
    a_parity_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
        strip_open_reg || !even_parity_reg)
        else $error("even parity with no strip open");

    // A run that ends on the end-strip slot consists of that slot alone
    a_end_run_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (last_slot_reg == SLOT_END) |-> slot_reg == SLOT_END)
        else $error("end-of-list run holds more than one result");

    // A result taken mid-run is followed by another result of the run
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        take && !done |=> out_valid)
        else $error("run cut short");

    // Nothing remains open on the output after an end strip that ends a run
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        done && (slot_reg == SLOT_END) && !accept |=> !strip_open_reg)
        else $error("strip still open after end of list");

endmodule
